@@ hw/rtl/pmq_pkg.sv @@
`timescale 1ns / 1ps

package pmq_pkg;

  // Queue geometry
  localparam int QDEPTH = 16;
  localparam int IDX_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Field widths
  localparam int PRI_W   = 3;
  localparam int SCR_W   = 4;
  localparam int TIME_W  = 32;
  localparam int MSG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_SCREEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDIT_SCREEN = 1'b1;

  // Reset values of the screen registers
  localparam logic [SCR_W-1:0] MAIN_SCREEN_RST = 4'd0;
  localparam logic [SCR_W-1:0] EDIT_SCREEN_RST = 4'd1;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_PURGE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_ACTIVATED = 3'd0,
    STS_QUEUED    = 3'd1,
    STS_DROPPED   = 3'd2,
    STS_REJECTED  = 3'd3,
    STS_DEQUEUED  = 3'd4,
    STS_EMPTY     = 3'd5,
    STS_DONE      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_READ,
    FS_EVAL
  } fsm_t;

  // One queued message
  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] dur;
    logic [SCR_W-1:0]  ret;
    logic [MSG_W-1:0]  msg;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/pmq_ram.sv @@
`timescale 1ns / 1ps

module pmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/priority_message_queue.sv @@
`timescale 1ns / 1ps
// Channel   Handshake          Ports
// -------   ----------------   ----------------------------------------------
// request   start & !busy      in_req_type .. in_current_time
// result    out_valid (1 clk)  out_status .. out_active_priority
// config    cfg_we             cfg_index, cfg_data
//
// Enqueue into an idle slot, clear, and dequeue/purge on an empty queue: no walk.
// Queued enqueue, dequeue and purge walk the queue RAM through one read port and
// one comparator, with a read state and an evaluate state for each entry visited.
// The result strobe rises in the cycle after the last step; busy is low by then.
// rst_n is synchronous; queue RAM contents are not cleared, the fill count is.
// The receiver cannot stall; a new item may be started while a result is shown.

module priority_message_queue
  import pmq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // request
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_req_type,
  input  logic [PRI_W-1:0]       in_priority_req,
  input  logic [TIME_W-1:0]      in_duration,
  input  logic [SCR_W-1:0]       in_return_screen,
  input  logic                   in_return_auto,
  input  logic [SCR_W-1:0]       in_current_screen,
  input  logic [MSG_W-1:0]       in_message_id,
  input  logic [TIME_W-1:0]      in_current_time,
  // result
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [PRI_W-1:0]       out_priority,
  output logic [TIME_W-1:0]      out_duration,
  output logic [SCR_W-1:0]       out_return,
  output logic [MSG_W-1:0]       out_message,
  output logic [CNT_W-1:0]       out_queue_count,
  output logic                   out_slot_live,
  output logic                   out_flash_expired,
  output logic [MSG_W-1:0]       out_active_message,
  output logic [PRI_W-1:0]       out_active_priority,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SCR_W-1:0]       cfg_data
);

  // Sequencer
  fsm_t state_r, state_nxt;
  logic fin;
  status_t fin_status;

  // Item context
  req_t op_r, op_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;
  entry_t ent_r, ent_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] wp_r, wp_nxt;
  logic drop_r, drop_nxt;

  // Queue and slot state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic slot_active_r, slot_active_nxt;
  logic [PRI_W-1:0] slot_pri_r, slot_pri_nxt;
  logic [TIME_W-1:0] slot_exp_r, slot_exp_nxt;
  logic [SCR_W-1:0] slot_ret_r, slot_ret_nxt;
  logic [MSG_W-1:0] slot_msg_r, slot_msg_nxt;
  logic [SCR_W-1:0] main_scr_r, main_scr_nxt;
  logic [SCR_W-1:0] edit_scr_r, edit_scr_nxt;

  // Result registers
  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic [PRI_W-1:0] out_pri_r, out_pri_nxt;
  logic [TIME_W-1:0] out_dur_r, out_dur_nxt;
  logic [SCR_W-1:0] out_ret_r, out_ret_nxt;
  logic [MSG_W-1:0] out_msg_r, out_msg_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic out_fa_r, out_fa_nxt;
  logic out_fe_r, out_fe_nxt;
  logic [MSG_W-1:0] out_am_r, out_am_nxt;
  logic [PRI_W-1:0] out_ap_r, out_ap_nxt;

  // Queue RAM port
  logic mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;
  logic [ENTRY_W-1:0] mem_rdata_raw;

  // Helpers
  logic [CNT_W-1:0] idx_m1, idx_p1;
  logic [TIME_W-1:0] now_cur;
  req_t cur_op, in_op;
  logic [SCR_W-1:0] auto_ret;

  pmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  assign mem_rdata = entry_t'(mem_rdata_raw);
  assign idx_m1    = idx_r - CNT_W'(1);
  assign idx_p1    = idx_r + CNT_W'(1);
  assign in_op     = req_t'(in_req_type);
  assign cur_op    = (state_r == FS_IDLE) ? in_op : op_r;
  assign now_cur   = (state_r == FS_IDLE) ? in_current_time : now_r;
  assign auto_ret  = (in_current_screen == edit_scr_r) ? main_scr_r : in_current_screen;
  // enqueue walks from the tail (index idx-1), the others from the head
  assign mem_raddr = (op_r == REQ_ENQ) ? idx_m1[IDX_W-1:0] : idx_r[IDX_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (start && !fin) begin
          state_nxt = FS_READ;
        end
      end
      FS_READ: state_nxt = fin ? FS_IDLE : FS_EVAL;
      FS_EVAL: state_nxt = fin ? FS_IDLE : FS_READ;
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    op_nxt          = op_r;
    pri_nxt         = pri_r;
    ent_nxt         = ent_r;
    now_nxt         = now_r;
    idx_nxt         = idx_r;
    wp_nxt          = wp_r;
    drop_nxt        = drop_r;
    count_nxt       = count_r;
    slot_active_nxt = slot_active_r;
    slot_pri_nxt    = slot_pri_r;
    slot_exp_nxt    = slot_exp_r;
    slot_ret_nxt    = slot_ret_r;
    slot_msg_nxt    = slot_msg_r;
    main_scr_nxt    = main_scr_r;
    edit_scr_nxt    = edit_scr_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_pri_nxt     = out_pri_r;
    out_dur_nxt     = out_dur_r;
    out_ret_nxt     = out_ret_r;
    out_msg_nxt     = out_msg_r;
    out_cnt_nxt     = out_cnt_r;
    out_fa_nxt      = out_fa_r;
    out_fe_nxt      = out_fe_r;
    out_am_nxt      = out_am_r;
    out_ap_nxt      = out_ap_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r[IDX_W-1:0];
    mem_wdata       = ent_r;
    fin             = 1'b0;
    fin_status      = STS_DONE;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAIN_SCREEN: main_scr_nxt = cfg_data;
        CFG_EDIT_SCREEN: edit_scr_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      FS_IDLE: begin
        if (start) begin
          op_nxt      = in_op;
          pri_nxt     = in_priority_req;
          now_nxt     = in_current_time;
          ent_nxt.pri = in_priority_req;
          ent_nxt.dur = in_duration;
          ent_nxt.msg = in_message_id;
          ent_nxt.ret = in_return_auto ? slot_ret_r : in_return_screen;
          idx_nxt     = '0;
          wp_nxt      = '0;
          drop_nxt    = 1'b0;
          case (in_op)
            REQ_ENQ: begin
              if (!slot_active_r) begin
                slot_active_nxt = 1'b1;
                slot_pri_nxt    = in_priority_req;
                slot_msg_nxt    = in_message_id;
                slot_exp_nxt    = in_current_time + in_duration;
                slot_ret_nxt    = in_return_auto ? auto_ret : in_return_screen;
                fin             = 1'b1;
                fin_status      = STS_ACTIVATED;
              end else begin
                // a full queue starts one past the end: the tail is tested first
                idx_nxt = count_r;
              end
            end
            REQ_DEQ: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = STS_EMPTY;
              end
            end
            REQ_PURGE: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = STS_DONE;
              end
            end
            REQ_CLEAR: begin
              slot_active_nxt = 1'b0;
              fin             = 1'b1;
              fin_status      = STS_DONE;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      FS_READ: begin
        // enqueue reaching the head: new item goes first
        if (op_r == REQ_ENQ && idx_r == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          mem_wdata  = ent_r;
          fin        = 1'b1;
          fin_status = drop_r ? STS_DROPPED : STS_QUEUED;
          count_nxt  = drop_r ? count_r : count_r + CNT_W'(1);
        end
      end

      FS_EVAL: begin
        case (op_r)
          REQ_ENQ: begin
            if (pri_r > mem_rdata.pri) begin
              // shift this entry back one place; past the end it falls off
              if (idx_r == CNT_W'(QDEPTH)) begin
                drop_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_r[IDX_W-1:0];
                mem_wdata = mem_rdata;
              end
              idx_nxt = idx_m1;
            end else if (idx_r == CNT_W'(QDEPTH)) begin
              fin        = 1'b1;
              fin_status = STS_REJECTED;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = idx_r[IDX_W-1:0];
              mem_wdata  = ent_r;
              fin        = 1'b1;
              fin_status = drop_r ? STS_DROPPED : STS_QUEUED;
              count_nxt  = drop_r ? count_r : count_r + CNT_W'(1);
            end
          end
          REQ_DEQ: begin
            if (idx_r == '0) begin
              out_pri_nxt = mem_rdata.pri;
              out_dur_nxt = mem_rdata.dur;
              out_ret_nxt = mem_rdata.ret;
              out_msg_nxt = mem_rdata.msg;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = idx_m1[IDX_W-1:0];
              mem_wdata = mem_rdata;
            end
            idx_nxt = idx_p1;
            if (idx_p1 == count_r) begin
              fin        = 1'b1;
              fin_status = STS_DEQUEUED;
              count_nxt  = count_r - CNT_W'(1);
            end
          end
          REQ_PURGE: begin
            // compact kept entries toward the head
            if (mem_rdata.pri >= pri_r) begin
              mem_we    = 1'b1;
              mem_waddr = wp_r[IDX_W-1:0];
              mem_wdata = mem_rdata;
              wp_nxt    = wp_r + CNT_W'(1);
            end
            idx_nxt = idx_p1;
            if (idx_p1 == count_r) begin
              fin        = 1'b1;
              fin_status = STS_DONE;
              count_nxt  = wp_nxt;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      default: ;
    endcase

    // load the result
    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_cnt_nxt    = count_nxt;
      out_fa_nxt     = slot_active_nxt;
      out_fe_nxt     = slot_active_nxt && (now_cur >= slot_exp_nxt);
      out_am_nxt     = slot_msg_nxt;
      out_ap_nxt     = slot_pri_nxt;
      if (fin_status != STS_DEQUEUED) begin
        out_pri_nxt = '0;
        out_dur_nxt = '0;
        out_msg_nxt = '0;
        out_ret_nxt = (cur_op == REQ_CLEAR) ? slot_ret_r : '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= FS_IDLE;
      count_r       <= '0;
      slot_active_r <= 1'b0;
      slot_pri_r    <= '0;
      slot_exp_r    <= '0;
      slot_ret_r    <= '0;
      slot_msg_r    <= '0;
      main_scr_r    <= MAIN_SCREEN_RST;
      edit_scr_r    <= EDIT_SCREEN_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      slot_active_r <= slot_active_nxt;
      slot_pri_r    <= slot_pri_nxt;
      slot_exp_r    <= slot_exp_nxt;
      slot_ret_r    <= slot_ret_nxt;
      slot_msg_r    <= slot_msg_nxt;
      main_scr_r    <= main_scr_nxt;
      edit_scr_r    <= edit_scr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pri_r        <= pri_nxt;
    ent_r        <= ent_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    wp_r         <= wp_nxt;
    drop_r       <= drop_nxt;
    out_status_r <= out_status_nxt;
    out_pri_r    <= out_pri_nxt;
    out_dur_r    <= out_dur_nxt;
    out_ret_r    <= out_ret_nxt;
    out_msg_r    <= out_msg_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_fa_r     <= out_fa_nxt;
    out_fe_r     <= out_fe_nxt;
    out_am_r     <= out_am_nxt;
    out_ap_r     <= out_ap_nxt;
  end

  assign busy                = (state_r != FS_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_priority        = out_pri_r;
  assign out_duration        = out_dur_r;
  assign out_return          = out_ret_r;
  assign out_message         = out_msg_r;
  assign out_queue_count     = out_cnt_r;
  assign out_slot_live       = out_fa_r;
  assign out_flash_expired   = out_fe_r;
  assign out_active_message  = out_am_r;
  assign out_active_priority = out_ap_r;

endmodule

@@ hw/rtl/pmq_checker.sv @@
`timescale 1ns / 1ps

module pmq_checker
  import pmq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [2:0]       out_status,
  input logic [CNT_W-1:0] out_queue_count,
  input logic             out_slot_live,
  input logic             out_flash_expired
);

  // An accepted item either runs the walk or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither busy nor answered");

  // Results only appear once the sequencer is back to idle
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Fill count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queue_count <= CNT_W'(QDEPTH)))
    else $error("queue count above depth");

  // Empty dequeue reports an empty queue
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_EMPTY) |-> (out_queue_count == '0))
    else $error("empty status with entries queued");

  // Expiry only for an active slot, and activation leaves it active
  a_flash_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_slot_live || !out_flash_expired) &&
                   (out_status != STS_ACTIVATED || out_slot_live)))
    else $error("inconsistent slot flags");

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_queue_count   (out_queue_count),
  .out_slot_live     (out_slot_live),
  .out_flash_expired (out_flash_expired)
);

@@ tb/sv/priority_message_queue_test.sv @@
`timescale 1ns / 1ps

module priority_message_queue_test;
  import pmq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  // One request as the sender presents it
  typedef struct {
    req_t              kind;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] dur;
    logic [SCR_W-1:0]  rscr;
    logic              rauto;
    logic [SCR_W-1:0]  cscr;
    logic [MSG_W-1:0]  msg;
    logic [TIME_W-1:0] now;
  } request_t;

  // One result as seen on the out_ ports
  typedef struct {
    logic [2:0]        status;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] dur;
    logic [SCR_W-1:0]  ret;
    logic [MSG_W-1:0]  msg;
    logic [CNT_W-1:0]  count;
    logic              flash_on;
    logic              expired;
    logic [MSG_W-1:0]  act_msg;
    logic [PRI_W-1:0]  act_pri;
  } result_t;

  // Shadow of the message slot and sorted queue, plus the results still owed
  class flash_queue_scoreboard;
    entry_t            q_mem [QDEPTH];
    int unsigned       q_len;
    logic              slot_on;
    logic [PRI_W-1:0]  slot_pri;
    logic [TIME_W-1:0] slot_exp;
    logic [SCR_W-1:0]  slot_ret;
    logic [MSG_W-1:0]  slot_msg;
    logic [SCR_W-1:0]  main_scr;
    logic [SCR_W-1:0]  edit_scr;
    result_t           expected_results[$];
    int unsigned       errors;

    function new();
      q_len    = 0;
      slot_on  = 1'b0;
      slot_pri = '0;
      slot_exp = '0;
      slot_ret = '0;
      slot_msg = '0;
      main_scr = MAIN_SCREEN_RST;
      edit_scr = EDIT_SCREEN_RST;
      errors   = 0;
    endfunction

    function void set_screen(logic [CFG_IDX_W-1:0] idx, logic [SCR_W-1:0] val);
      if (idx == CFG_MAIN_SCREEN) main_scr = val;
      else edit_scr = val;
    endfunction

    // Insert behind all entries of equal or higher priority
    function void insert_sorted(entry_t e);
      int unsigned pos;
      pos = q_len;
      for (int unsigned i = 0; i < q_len; i++) begin
        if (e.pri > q_mem[i].pri) begin
          pos = i;
          break;
        end
      end
      for (int unsigned i = q_len; i > pos; i--) q_mem[i] = q_mem[i-1];
      q_mem[pos] = e;
      q_len++;
    endfunction

    // Work out the result of an accepted request and queue it
    function void note_request(request_t r);
      result_t     x;
      entry_t      e;
      int unsigned kept;
      x        = '{default: '0};
      x.status = STS_DONE;
      case (r.kind)
        REQ_ENQ: begin
          if (!slot_on) begin
            if (!r.rauto) slot_ret = r.rscr;
            else if (r.cscr == edit_scr) slot_ret = main_scr;
            else slot_ret = r.cscr;
            slot_msg = r.msg;
            slot_pri = r.pri;
            slot_exp = r.now + r.dur;
            slot_on  = 1'b1;
            x.status = STS_ACTIVATED;
          end else begin
            e.pri = r.pri;
            e.dur = r.dur;
            e.ret = r.rauto ? slot_ret : r.rscr;
            e.msg = r.msg;
            if (q_len < QDEPTH) begin
              insert_sorted(e);
              x.status = STS_QUEUED;
            end else if (r.pri > q_mem[QDEPTH-1].pri) begin
              q_len = QDEPTH - 1;
              insert_sorted(e);
              x.status = STS_DROPPED;
            end else begin
              x.status = STS_REJECTED;
            end
          end
        end
        REQ_DEQ: begin
          if (q_len == 0) begin
            x.status = STS_EMPTY;
          end else begin
            x.pri = q_mem[0].pri;
            x.dur = q_mem[0].dur;
            x.ret = q_mem[0].ret;
            x.msg = q_mem[0].msg;
            for (int unsigned i = 0; i + 1 < q_len; i++) q_mem[i] = q_mem[i+1];
            q_len--;
            x.status = STS_DEQUEUED;
          end
        end
        REQ_PURGE: begin
          kept = 0;
          for (int unsigned i = 0; i < q_len; i++) begin
            if (q_mem[i].pri >= r.pri) begin
              q_mem[kept] = q_mem[i];
              kept++;
            end
          end
          q_len = kept;
        end
        default: begin
          x.ret   = slot_ret;
          slot_on = 1'b0;
        end
      endcase
      x.count    = CNT_W'(q_len);
      x.flash_on = slot_on;
      x.expired  = slot_on && (r.now >= slot_exp);
      x.act_msg  = slot_msg;
      x.act_pri  = slot_pri;
      expected_results.push_back(x);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("priority", 32'(want.pri), 32'(got.pri));
      compare_field("duration", want.dur, got.dur);
      compare_field("return", 32'(want.ret), 32'(got.ret));
      compare_field("message", 32'(want.msg), 32'(got.msg));
      compare_field("queue_count", 32'(want.count), 32'(got.count));
      compare_field("slot_live", 32'(want.flash_on), 32'(got.flash_on));
      compare_field("flash_expired", 32'(want.expired), 32'(got.expired));
      compare_field("active_message", 32'(want.act_msg), 32'(got.act_msg));
      compare_field("active_priority", 32'(want.act_pri), 32'(got.act_pri));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_req_type;
  logic [PRI_W-1:0]     in_priority_req;
  logic [TIME_W-1:0]    in_duration;
  logic [SCR_W-1:0]     in_return_screen;
  logic                 in_return_auto;
  logic [SCR_W-1:0]     in_current_screen;
  logic [MSG_W-1:0]     in_message_id;
  logic [TIME_W-1:0]    in_current_time;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [PRI_W-1:0]     out_priority;
  logic [TIME_W-1:0]    out_duration;
  logic [SCR_W-1:0]     out_return;
  logic [MSG_W-1:0]     out_message;
  logic [CNT_W-1:0]     out_queue_count;
  logic                 out_slot_live;
  logic                 out_flash_expired;
  logic [MSG_W-1:0]     out_active_message;
  logic [PRI_W-1:0]     out_active_priority;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCR_W-1:0]     cfg_data;

  flash_queue_scoreboard sb = new();
  logic [TIME_W-1:0]     wall_ms = '0;
  bit                    gapless = 1'b0;
  int unsigned           cycles = 0;

  priority_message_queue dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("priority_message_queue_test: done, errors");
      $finish;
    end
  end

  // Result monitor: the strobe lasts one cycle, sampled at the closing edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid) begin
      got.status   = out_status;
      got.pri      = out_priority;
      got.dur      = out_duration;
      got.ret      = out_return;
      got.msg      = out_message;
      got.count    = out_queue_count;
      got.flash_on = out_slot_live;
      got.expired  = out_flash_expired;
      got.act_msg  = out_active_message;
      got.act_pri  = out_active_priority;
      sb.check_result(got);
    end
  end

  function automatic request_t make_request(req_t kind, logic [PRI_W-1:0] pri,
                                            logic [TIME_W-1:0] dur, logic [SCR_W-1:0] rscr,
                                            logic rauto, logic [SCR_W-1:0] cscr,
                                            logic [MSG_W-1:0] msg, logic [TIME_W-1:0] now);
    request_t r;
    r.kind  = kind;
    r.pri   = pri;
    r.dur   = dur;
    r.rscr  = rscr;
    r.rauto = rauto;
    r.cscr  = cscr;
    r.msg   = msg;
    r.now   = now;
    return r;
  endfunction

  // Random request; enq_pct sets how hard the queue is filled
  function automatic request_t random_request(int unsigned enq_pct);
    request_t    r;
    int unsigned roll;
    // time mostly creeps forward, sometimes jumps or nears the wrap
    case ($urandom_range(0, 59))
      0:       wall_ms = $urandom;
      1:       wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      default: wall_ms = wall_ms + $urandom_range(0, 60);
    endcase
    r.now = wall_ms;
    case ($urandom_range(0, 9))
      0:       r.dur = '0;
      1:       r.dur = '1;
      2:       r.dur = $urandom;
      default: r.dur = $urandom_range(0, 400);
    endcase
    r.pri   = PRI_W'($urandom_range(0, 7));
    r.rscr  = SCR_W'($urandom_range(0, 15));
    r.rauto = 1'($urandom_range(0, 1));
    r.cscr  = ($urandom_range(0, 3) == 0) ? sb.edit_scr : SCR_W'($urandom_range(0, 15));
    r.msg   = MSG_W'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      r.kind = REQ_ENQ;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        r.kind = REQ_DEQ;
      end else if (roll < 7) begin
        r.kind = REQ_PURGE;
        if ($urandom_range(0, 1)) r.pri = PRI_W'($urandom_range(0, 3));
      end else begin
        r.kind = REQ_CLEAR;
      end
    end
    return r;
  endfunction

  // Drive one item after a random gap and hold it until accepted
  task automatic issue_request(request_t r);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_req_type       <= r.kind;
    in_priority_req   <= r.pri;
    in_duration       <= r.dur;
    in_return_screen  <= r.rscr;
    in_return_auto    <= r.rauto;
    in_current_screen <= r.cscr;
    in_message_id     <= r.msg;
    in_current_time   <= r.now;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  // Stop sending and wait out every owed result
  task automatic drain_results(int unsigned settle);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write both screen registers back to back
  task automatic write_screens(logic [SCR_W-1:0] main_val, logic [SCR_W-1:0] edit_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAIN_SCREEN;
    cfg_data  <= main_val;
    @(posedge clk);
    sb.set_screen(CFG_MAIN_SCREEN, main_val);
    cfg_index <= CFG_EDIT_SCREEN;
    cfg_data  <= edit_val;
    @(posedge clk);
    sb.set_screen(CFG_EDIT_SCREEN, edit_val);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned      weight;
    logic [SCR_W-1:0] m_scr;
    logic [SCR_W-1:0] e_scr;

    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_req_type       <= REQ_ENQ;
    in_priority_req   <= '0;
    in_duration       <= '0;
    in_return_screen  <= '0;
    in_return_auto    <= 1'b0;
    in_current_screen <= '0;
    in_message_id     <= '0;
    in_current_time   <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_MAIN_SCREEN;
    cfg_data          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, idle slot, auto capture of the edit screen,
    // wrapped expiry, inheritance, stable order, purge, expiry boundary
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, '0));
    issue_request(make_request(REQ_PURGE, 3'd7, '0, 4'd0, 1'b0, 4'd0, 16'd0, '0));
    issue_request(make_request(REQ_CLEAR, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, '0));
    issue_request(make_request(REQ_ENQ, 3'd0, '1, 4'd7, 1'b1, 4'd1, 16'd0, '1));
    issue_request(make_request(REQ_ENQ, 3'd7, '1, 4'd15, 1'b0, 4'd3, 16'hFFFF, '0));
    issue_request(make_request(REQ_ENQ, 3'd0, 32'd10, 4'd2, 1'b1, 4'd5, 16'd10, 32'd5));
    issue_request(make_request(REQ_ENQ, 3'd3, 32'd20, 4'd4, 1'b0, 4'd5, 16'd1, 32'd6));
    issue_request(make_request(REQ_ENQ, 3'd3, 32'd30, 4'd6, 1'b0, 4'd5, 16'd2, 32'd7));
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd8));
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd9));
    issue_request(make_request(REQ_PURGE, 3'd3, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd9));
    issue_request(make_request(REQ_PURGE, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd9));
    issue_request(make_request(REQ_CLEAR, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd9));
    issue_request(make_request(REQ_CLEAR, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd9));
    issue_request(make_request(REQ_ENQ, 3'd5, 32'd50, 4'd0, 1'b1, 4'd9, 16'd20, 32'd100));
    issue_request(make_request(REQ_ENQ, 3'd2, 32'd1, 4'd8, 1'b0, 4'd0, 16'd21, 32'd149));
    issue_request(make_request(REQ_ENQ, 3'd2, 32'd2, 4'd0, 1'b1, 4'd0, 16'd22, 32'd150));
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd151));
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd152));
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd153));
    issue_request(make_request(REQ_DEQ, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd154));
    issue_request(make_request(REQ_CLEAR, 3'd0, '0, 4'd0, 1'b0, 4'd0, 16'd0, 32'd155));

    // Random phases, each under its own screen setting
    for (int p = 0; p < 6; p++) begin
      drain_results(4);
      case (p)
        0: begin m_scr = 4'd15; e_scr = 4'd0;  weight = 85; end
        1: begin m_scr = 4'd0;  e_scr = 4'd15; weight = 40; end
        2: begin m_scr = 4'd15; e_scr = 4'd15; weight = 70; end
        3: begin m_scr = 4'd0;  e_scr = 4'd0;  weight = 55; end
        default: begin
          m_scr  = SCR_W'($urandom_range(0, 15));
          e_scr  = SCR_W'($urandom_range(0, 15));
          weight = (p == 4) ? 90 : 50;
        end
      endcase
      write_screens(m_scr, e_scr);
      for (int n = 0; n < 180; n++) begin
        if (n % 30 == 0) gapless = ($urandom_range(0, 2) == 0);
        issue_request(random_request(weight));
      end
    end

    drain_results(2 * QDEPTH + 4);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("priority_message_queue_test: done, clean");
    end else begin
      $display("priority_message_queue_test: done, errors");
    end
    $finish;
  end

endmodule
